FILE: hw/rtl/clm_pkg.sv
package clm_pkg;

    localparam int CAPACITY = 16;
    localparam int SLOT_W   = 4;
    localparam int COUNT_W  = 5;
    localparam int VALUE_W  = 32;
    localparam int STEPS_W  = 16;
    localparam int BIT_W    = 4;

    typedef enum logic [2:0] {
        MODE_PUSH_FRONT = 3'd0,
        MODE_PUSH_BACK  = 3'd1,
        MODE_ERASE      = 3'd2,
        MODE_FIND       = 3'd3,
        MODE_ADVANCE    = 3'd4,
        MODE_ROUND      = 3'd5,
        MODE_CLEAR      = 3'd6,
        MODE_HEAD       = 3'd7
    } t_mode;

    typedef enum logic [2:0] {
        ST_OK        = 3'd0,
        ST_FULL      = 3'd1,
        ST_NOT_FOUND = 3'd2,
        ST_EMPTY     = 3'd3,
        ST_INVALID   = 3'd4
    } t_status;

    typedef enum logic [1:0] {
        VS_ZERO  = 2'd0,
        VS_INPUT = 2'd1,
        VS_READ  = 2'd2
    } t_vsel;

    typedef enum logic [1:0] {
        HS_ZERO   = 2'd0,
        HS_CUR    = 2'd1,
        HS_HANDLE = 2'd2,
        HS_SLOT   = 2'd3
    } t_hsel;

    typedef struct packed {
        t_mode                mode;
        logic [VALUE_W-1:0]   value;
        logic [SLOT_W-1:0]    handle;
        logic [STEPS_W-1:0]   steps;
    } t_in;

    typedef struct packed {
        t_status              status;
        logic [VALUE_W-1:0]   value_out;
        logic [SLOT_W-1:0]    handle_out;
        logic [COUNT_W-1:0]   count;
        logic                 last;
    } t_out;

    typedef struct packed {
        logic    load;
        logic    rd;
        logic    rd_link;
        logic    step;
        logic    push_a;
        logic    push_b;
        logic    erase;
        logic    clear;
        logic    div;
        logic    adv;
        logic    emit;
        t_status status;
        t_vsel   vsel;
        t_hsel   hsel;
        logic    last;
    } t_dp_cmd;

    typedef struct packed {
        logic count_zero;
        logic full;
        logic h_used;
        logic match;
        logic idx_last;
        logic rem_zero;
        logic div_last;
    } t_dp_flags;

endpackage

FILE: hw/rtl/clm_datapath.sv
module clm_datapath (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  clm_pkg::t_in       i_cmd,
    input  clm_pkg::t_dp_cmd   i_ctl,
    output clm_pkg::t_dp_flags o_flags,
    output logic               o_valid,
    output clm_pkg::t_out      o_result
);
    import clm_pkg::*;

    logic [VALUE_W-1:0] mem_value [CAPACITY];
    logic [SLOT_W-1:0]  mem_link  [CAPACITY];

    t_in                r_in;
    logic [CAPACITY-1:0] r_used;
    logic [SLOT_W-1:0]  r_tail, r_head, r_cur, r_prev, r_slot;
    logic [SLOT_W-1:0]  r_idx, r_rem;
    logic [BIT_W-1:0]   r_bit;
    logic [COUNT_W-1:0] r_count, n_count;
    logic [VALUE_W-1:0] r_rd_value;
    logic [SLOT_W-1:0]  r_rd_link;
    logic               r_valid;
    t_out               r_result;

    logic [SLOT_W-1:0]  free_slot;
    logic [SLOT_W-1:0]  rd_addr;
    logic               link_we;
    logic [SLOT_W-1:0]  link_addr, link_data;
    logic [COUNT_W-1:0] trial, trial_sub;
    logic [SLOT_W-1:0]  n_rem;
    logic               count_zero, count_one;

    assign count_zero = (r_count == '0);
    assign count_one  = (r_count == COUNT_W'(1));

    // lowest free slot
    always_comb begin
        free_slot = '0;
        for (int i = CAPACITY - 1; i >= 0; i--) begin
            if (!r_used[i]) begin
                free_slot = SLOT_W'(i);
            end
        end
    end

    // one restoring step of steps mod count
    assign trial     = {r_rem, r_in.steps[r_bit]};
    assign trial_sub = trial - r_count;
    assign n_rem     = (trial >= r_count) ? trial_sub[SLOT_W-1:0] : trial[SLOT_W-1:0];

    always_comb begin
        n_count = r_count;
        if (i_ctl.push_b) begin
            n_count = r_count + COUNT_W'(1);
        end else if (i_ctl.erase) begin
            n_count = r_count - COUNT_W'(1);
        end else if (i_ctl.clear) begin
            n_count = '0;
        end
    end

    always_comb begin
        link_we   = 1'b0;
        link_addr = free_slot;
        link_data = count_zero ? free_slot : r_head;
        if (i_ctl.push_a) begin
            link_we = 1'b1;
        end else if (i_ctl.push_b) begin
            link_we   = !count_zero;
            link_addr = r_tail;
            link_data = r_slot;
        end else if (i_ctl.erase) begin
            link_we   = !count_one;
            link_addr = r_prev;
            link_data = r_rd_link;
        end
    end

    assign rd_addr = i_ctl.rd_link ? r_rd_link : r_cur;

    always_ff @(posedge i_clk) begin
        if (i_ctl.push_a) begin
            mem_value[free_slot] <= r_in.value;
        end
        if (link_we) begin
            mem_link[link_addr] <= link_data;
        end
        if (i_ctl.rd) begin
            r_rd_value <= mem_value[rd_addr];
            r_rd_link  <= mem_link[rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_used  <= '0;
            r_tail  <= '0;
            r_head  <= '0;
            r_count <= '0;
            r_valid <= 1'b0;
        end else begin
            r_valid <= i_ctl.emit;
            r_count <= n_count;
            if (i_ctl.push_a) begin
                r_used[free_slot] <= 1'b1;
            end
            if (i_ctl.push_b) begin
                if (count_zero) begin
                    r_head <= r_slot;
                    r_tail <= r_slot;
                end else if (r_in.mode == MODE_PUSH_FRONT) begin
                    r_head <= r_slot;
                end else begin
                    r_tail <= r_slot;
                end
            end
            if (i_ctl.erase) begin
                r_used[r_cur] <= 1'b0;
                if (count_one) begin
                    r_tail <= '0;
                end else begin
                    if (r_cur == r_tail) begin
                        r_tail <= r_prev;
                    end
                    if (r_cur == r_head) begin
                        r_head <= r_rd_link;
                    end
                end
            end
            if (i_ctl.clear) begin
                r_used <= '0;
                r_tail <= '0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.load) begin
            r_in   <= i_cmd;
            r_cur  <= (i_cmd.mode == MODE_ADVANCE) ? i_cmd.handle : r_head;
            r_prev <= r_tail;
            r_idx  <= '0;
            r_rem  <= '0;
            r_bit  <= BIT_W'(STEPS_W - 1);
        end
        if (i_ctl.step) begin
            r_prev <= r_cur;
            r_cur  <= r_rd_link;
            r_idx  <= r_idx + SLOT_W'(1);
        end
        if (i_ctl.push_a) begin
            r_slot <= free_slot;
        end
        if (i_ctl.div) begin
            r_rem <= n_rem;
            r_bit <= r_bit - BIT_W'(1);
        end
        if (i_ctl.adv) begin
            r_cur <= r_rd_link;
            r_rem <= r_rem - SLOT_W'(1);
        end
        if (i_ctl.emit) begin
            r_result.status <= i_ctl.status;
            case (i_ctl.vsel)
                VS_INPUT: r_result.value_out <= r_in.value;
                VS_READ:  r_result.value_out <= r_rd_value;
                default:  r_result.value_out <= '0;
            endcase
            case (i_ctl.hsel)
                HS_CUR:    r_result.handle_out <= r_cur;
                HS_HANDLE: r_result.handle_out <= r_in.handle;
                HS_SLOT:   r_result.handle_out <= r_slot;
                default:   r_result.handle_out <= '0;
            endcase
            r_result.count <= n_count;
            r_result.last  <= i_ctl.last;
        end
    end

    assign o_flags.count_zero = count_zero;
    assign o_flags.full       = (r_count == COUNT_W'(CAPACITY));
    assign o_flags.h_used     = r_used[r_in.handle];
    assign o_flags.match      = (r_rd_value == r_in.value);
    assign o_flags.idx_last   = ({1'b0, r_idx} + COUNT_W'(1)) == r_count;
    assign o_flags.rem_zero   = (r_rem == '0);
    assign o_flags.div_last   = (r_bit == '0);

    assign o_valid  = r_valid;
    assign o_result = r_result;

endmodule

FILE: hw/rtl/clm_controller.sv
module clm_controller (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_start,
    input  clm_pkg::t_mode     i_mode,
    input  clm_pkg::t_dp_flags i_flags,
    output logic               o_busy,
    output clm_pkg::t_dp_cmd   o_ctl
);
    import clm_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE, S_DISPATCH, S_PUSH_A, S_PUSH_B, S_WALK, S_ROUND,
        S_HEAD, S_DIV, S_ADV_RD, S_ADV
    } t_state;

    t_state r_state, n_state;
    t_mode  r_mode;

    assign o_busy = (r_state != S_IDLE);

    always_comb begin
        o_ctl        = '0;
        o_ctl.status = ST_OK;
        o_ctl.vsel   = VS_ZERO;
        o_ctl.hsel   = HS_ZERO;
        o_ctl.last   = 1'b1;
        n_state      = r_state;
        case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    o_ctl.load = 1'b1;
                    n_state    = S_DISPATCH;
                end
            end
            S_DISPATCH: begin
                if (r_mode == MODE_PUSH_FRONT || r_mode == MODE_PUSH_BACK) begin
                    if (i_flags.full) begin
                        o_ctl.emit   = 1'b1;
                        o_ctl.status = ST_FULL;
                        o_ctl.vsel   = VS_INPUT;
                        n_state      = S_IDLE;
                    end else begin
                        n_state = S_PUSH_A;
                    end
                end else if (r_mode == MODE_CLEAR) begin
                    o_ctl.clear = 1'b1;
                    o_ctl.emit  = 1'b1;
                    n_state     = S_IDLE;
                end else if (r_mode == MODE_ADVANCE && !i_flags.count_zero
                             && !i_flags.h_used) begin
                    o_ctl.emit   = 1'b1;
                    o_ctl.status = ST_INVALID;
                    o_ctl.hsel   = HS_HANDLE;
                    n_state      = S_IDLE;
                end else if (i_flags.count_zero) begin
                    o_ctl.emit   = 1'b1;
                    o_ctl.status = ST_EMPTY;
                    n_state      = S_IDLE;
                end else if (r_mode == MODE_ADVANCE) begin
                    n_state = S_DIV;
                end else begin
                    o_ctl.rd = 1'b1;
                    if (r_mode == MODE_ROUND) begin
                        n_state = S_ROUND;
                    end else if (r_mode == MODE_HEAD) begin
                        n_state = S_HEAD;
                    end else begin
                        n_state = S_WALK;
                    end
                end
            end
            S_PUSH_A: begin
                o_ctl.push_a = 1'b1;
                n_state      = S_PUSH_B;
            end
            S_PUSH_B: begin
                o_ctl.push_b = 1'b1;
                o_ctl.emit   = 1'b1;
                o_ctl.vsel   = VS_INPUT;
                o_ctl.hsel   = HS_SLOT;
                n_state      = S_IDLE;
            end
            S_WALK: begin
                if (i_flags.match) begin
                    o_ctl.erase = (r_mode == MODE_ERASE);
                    o_ctl.emit  = 1'b1;
                    o_ctl.vsel  = VS_INPUT;
                    o_ctl.hsel  = HS_CUR;
                    n_state     = S_IDLE;
                end else if (i_flags.idx_last) begin
                    o_ctl.emit   = 1'b1;
                    o_ctl.status = ST_NOT_FOUND;
                    o_ctl.vsel   = VS_INPUT;
                    n_state      = S_IDLE;
                end else begin
                    o_ctl.step    = 1'b1;
                    o_ctl.rd      = 1'b1;
                    o_ctl.rd_link = 1'b1;
                end
            end
            S_ROUND: begin
                o_ctl.emit = 1'b1;
                o_ctl.vsel = VS_READ;
                o_ctl.hsel = HS_CUR;
                o_ctl.last = i_flags.idx_last;
                if (i_flags.idx_last) begin
                    n_state = S_IDLE;
                end else begin
                    o_ctl.step    = 1'b1;
                    o_ctl.rd      = 1'b1;
                    o_ctl.rd_link = 1'b1;
                end
            end
            S_HEAD: begin
                o_ctl.emit = 1'b1;
                o_ctl.vsel = VS_READ;
                o_ctl.hsel = HS_CUR;
                n_state    = S_IDLE;
            end
            S_DIV: begin
                o_ctl.div = 1'b1;
                if (i_flags.div_last) begin
                    n_state = S_ADV_RD;
                end
            end
            S_ADV_RD: begin
                o_ctl.rd = 1'b1;
                n_state  = S_ADV;
            end
            S_ADV: begin
                if (i_flags.rem_zero) begin
                    o_ctl.emit = 1'b1;
                    o_ctl.vsel = VS_READ;
                    o_ctl.hsel = HS_CUR;
                    n_state    = S_IDLE;
                end else begin
                    o_ctl.adv     = 1'b1;
                    o_ctl.rd      = 1'b1;
                    o_ctl.rd_link = 1'b1;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_mode  <= MODE_HEAD;
        end else begin
            r_state <= n_state;
            if (r_state == S_IDLE && i_start) begin
                r_mode <= i_mode;
            end
        end
    end

endmodule

FILE: hw/rtl/circular_list_manager.sv
// channel   | ports                      | transaction
// ----------+----------------------------+------------------------------------
// command   | start, busy, i_cmd         | taken at an edge with start & !busy
// result    | o_valid, o_result          | one cycle per result, last marked
//
// busy from the accepting edge until the result is formed; a result shows in
// the cycle after. push stores, then links the node; clear, empty, full and bad
// handle answer at dispatch; head reads the head node; erase/find read one node
// per cycle; round shows each node; advance takes steps mod count, then walks it.
// synchronous active-low reset empties the list; node stores are not cleared.
// results cannot be stalled.
module circular_list_manager (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          start,
    output logic          busy,
    input  clm_pkg::t_in  i_cmd,
    output logic          o_valid,
    output clm_pkg::t_out o_result
);
    import clm_pkg::*;

    t_dp_cmd   ctl;
    t_dp_flags flags;

    clm_controller u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (start),
        .i_mode  (i_cmd.mode),
        .i_flags (flags),
        .o_busy  (busy),
        .o_ctl   (ctl)
    );

    clm_datapath u_dp (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cmd    (i_cmd),
        .i_ctl    (ctl),
        .o_flags  (flags),
        .o_valid  (o_valid),
        .o_result (o_result)
    );

    a_last_gap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_result.last |=> !o_valid)
        else $error("result right after a last result");

    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_result.count <= COUNT_W'(CAPACITY))
        else $error("count beyond capacity");

    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        start && !busy |=> busy)
        else $error("not busy after accepting a command");

endmodule
